>>> rtl/ppr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int ADDR_BITS   = 48;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int QW          = ADDR_BITS + 1;
  localparam int PAGE_BITS   = 12;
  localparam int FLAG_W      = 12;
  localparam int RIGHTS_W    = 3;
  localparam int SHIFT_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 48;

  localparam int HPS_MIN   = 12;
  localparam int HPS_MAX   = 16;
  localparam int HPS_RESET = 14;

  localparam int R_BIT = 0;
  localparam int W_BIT = 1;
  localparam int X_BIT = 2;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_UNION  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WX   = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_SIZE  = 3'd0,
    CFG_HPS       = 3'd1,
    CFG_FLAGS_RW  = 3'd2,
    CFG_FLAGS_RX  = 3'd3,
    CFG_FLAGS_RO  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_REC,
    S_SCAN,
    S_LAST,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic [RIGHTS_W-1:0]  rights;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic prep;
    logic rec;
    logic scan_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  count_zero;
    logic  scan_last;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/page_protection_range_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_stall   kind, range_begin, range_limit, access_rights, page_address
// out      out_valid / out_stall status, covered, found_rights, page_entry, host/stage-2 flags
// cfg      cfg_wr_en             cfg_index, cfg_wdata (no read-back)
//
// One transaction at a time. A record passes through PREP, REC and FIN. A lookup or union
// passes through PREP, SCAN, LAST and FIN, scanning its N stored ranges (1 to 16) one per
// cycle through the registered RAM read; an empty table or an unused kind skips the scan.
// A finished result waits in the output register while the next transaction runs; a later
// result waits for it with the input stalled, for as long as the output stalls.
// Reset (synchronous, rst_n low) empties the table and restores the register defaults.
module page_protection_range_table_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ppr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ppr_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [ppr_pkg::ADDR_BITS-1:0]     in_range_begin,
  input  wire logic [ppr_pkg::ADDR_BITS-1:0]     in_range_limit,
  input  wire logic [ppr_pkg::RIGHTS_W-1:0]      in_access_rights,
  input  wire logic [ppr_pkg::ADDR_BITS-1:0]     in_page_address,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_status,
  output logic                                   out_covered,
  output logic [ppr_pkg::RIGHTS_W-1:0]           out_found_rights,
  output logic [ppr_pkg::ADDR_BITS-1:0]          out_page_entry,
  output logic                                   out_host_write,
  output logic                                   out_stage2_read,
  output logic                                   out_stage2_write,
  output logic                                   out_stage2_exec
);

  ppr_pkg::cmd_t  cmd;
  ppr_pkg::stat_t st;

  ppr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  ppr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_range_begin  (in_range_begin),
    .in_range_limit  (in_range_limit),
    .in_access_rights(in_access_rights),
    .in_page_address (in_page_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_covered     (out_covered),
    .out_found_rights(out_found_rights),
    .out_page_entry  (out_page_entry),
    .out_host_write  (out_host_write),
    .out_stage2_read (out_stage2_read),
    .out_stage2_write(out_stage2_write),
    .out_stage2_exec (out_stage2_exec)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.prep, cmd.rec, cmd.scan_rd, cmd.load_out}))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("input not stalled while a transaction is in progress");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over one not yet taken");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_rd && st.scan_last) |=> !cmd.scan_rd)
    else $error("table scan ran past the last stored range");

endmodule

`default_nettype wire

>>> rtl/ppr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/ppr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ppr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ppr_pkg::stat_t  st,
  output ppr_pkg::cmd_t        cmd
);

  ppr_pkg::state_t state_r;
  ppr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ppr_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ppr_pkg::S_PREP;
        end
      end
      ppr_pkg::S_PREP: begin
        cmd.prep = 1'b1;
        unique case (st.kind) inside
          ppr_pkg::KIND_RECORD: state_nxt = ppr_pkg::S_REC;
          ppr_pkg::KIND_LOOKUP, ppr_pkg::KIND_UNION: begin
            state_nxt = st.count_zero ? ppr_pkg::S_FIN : ppr_pkg::S_SCAN;
          end
          default: state_nxt = ppr_pkg::S_FIN;
        endcase
      end
      ppr_pkg::S_REC: begin
        cmd.rec   = 1'b1;
        state_nxt = ppr_pkg::S_FIN;
      end
      ppr_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) begin
          state_nxt = ppr_pkg::S_LAST;
        end
      end
      // The last entry's read data arrives here and is compared.
      ppr_pkg::S_LAST: begin
        state_nxt = ppr_pkg::S_FIN;
      end
      ppr_pkg::S_FIN: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ppr_pkg::S_IDLE;
        end
      end
      default: state_nxt = ppr_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ppr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ppr_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ppr_pkg::cmd_t                         cmd,
  output ppr_pkg::stat_t                             st,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [ppr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ppr_pkg::CFG_W-1:0]             cfg_wdata,
  input  wire logic [1:0]                            in_kind,
  input  wire logic [ppr_pkg::ADDR_BITS-1:0]         in_range_begin,
  input  wire logic [ppr_pkg::ADDR_BITS-1:0]         in_range_limit,
  input  wire logic [ppr_pkg::RIGHTS_W-1:0]          in_access_rights,
  input  wire logic [ppr_pkg::ADDR_BITS-1:0]         in_page_address,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [1:0]                                 out_status,
  output logic                                       out_covered,
  output logic [ppr_pkg::RIGHTS_W-1:0]               out_found_rights,
  output logic [ppr_pkg::ADDR_BITS-1:0]              out_page_entry,
  output logic                                       out_host_write,
  output logic                                       out_stage2_read,
  output logic                                       out_stage2_write,
  output logic                                       out_stage2_exec
);

  // Configuration registers.
  logic [ppr_pkg::ADDR_BITS-1:0] mem_bytes_r;
  logic [ppr_pkg::SHIFT_W-1:0]   hps_r;
  logic [ppr_pkg::FLAG_W-1:0]    flags_rw_r;
  logic [ppr_pkg::FLAG_W-1:0]    flags_rx_r;
  logic [ppr_pkg::FLAG_W-1:0]    flags_ro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r <= '0;
      hps_r       <= ppr_pkg::SHIFT_W'(ppr_pkg::HPS_RESET);
      flags_rw_r  <= '0;
      flags_rx_r  <= '0;
      flags_ro_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ppr_pkg::CFG_MEM_SIZE: mem_bytes_r <= cfg_wdata[ppr_pkg::ADDR_BITS-1:0];
        ppr_pkg::CFG_HPS:      hps_r       <= cfg_wdata[ppr_pkg::SHIFT_W-1:0];
        ppr_pkg::CFG_FLAGS_RW: flags_rw_r  <= cfg_wdata[ppr_pkg::FLAG_W-1:0];
        ppr_pkg::CFG_FLAGS_RX: flags_rx_r  <= cfg_wdata[ppr_pkg::FLAG_W-1:0];
        ppr_pkg::CFG_FLAGS_RO: flags_ro_r  <= cfg_wdata[ppr_pkg::FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched transaction.
  ppr_pkg::kind_t                kind_r;
  logic [ppr_pkg::ADDR_BITS-1:0] begin_r;
  logic [ppr_pkg::ADDR_BITS-1:0] limit_r;
  logic [ppr_pkg::RIGHTS_W-1:0]  rights_r;
  logic [ppr_pkg::ADDR_BITS-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= ppr_pkg::kind_t'(in_kind);
      begin_r  <= in_range_begin;
      limit_r  <= in_range_limit;
      rights_r <= in_access_rights;
      addr_r   <= in_page_address;
    end
  end

  // Query window [q_lo, q_hi): the base of the 4K page for a lookup, one host page for a union.
  logic [ppr_pkg::SHIFT_W-1:0]   sh_c;
  logic [ppr_pkg::QW-1:0]        hps;
  logic [ppr_pkg::ADDR_BITS-1:0] hmask;
  logic [ppr_pkg::ADDR_BITS-1:0] q_lo_nxt;
  logic [ppr_pkg::QW-1:0]        q_hi_nxt;
  logic                          bad_nxt;
  logic [ppr_pkg::ADDR_BITS-1:0] q_lo_r;
  logic [ppr_pkg::QW-1:0]        q_hi_r;
  logic                          bad_r;

  always_comb begin
    if (hps_r < ppr_pkg::SHIFT_W'(ppr_pkg::HPS_MIN)) begin
      sh_c = ppr_pkg::SHIFT_W'(ppr_pkg::HPS_MIN);
    end else if (hps_r > ppr_pkg::SHIFT_W'(ppr_pkg::HPS_MAX)) begin
      sh_c = ppr_pkg::SHIFT_W'(ppr_pkg::HPS_MAX);
    end else begin
      sh_c = hps_r;
    end
    hps   = ppr_pkg::QW'(1) << sh_c;
    hmask = ~(hps[ppr_pkg::ADDR_BITS-1:0] - ppr_pkg::ADDR_BITS'(1));
    if (kind_r == ppr_pkg::KIND_UNION) begin
      q_lo_nxt = addr_r & hmask;
      q_hi_nxt = {1'b0, q_lo_nxt} + hps;
    end else begin
      q_lo_nxt = {addr_r[ppr_pkg::ADDR_BITS-1:ppr_pkg::PAGE_BITS],
                  {ppr_pkg::PAGE_BITS{1'b0}}};
      q_hi_nxt = {1'b0, q_lo_nxt} + ppr_pkg::QW'(1);
    end
    // With an aligned start, the length is a 4K multiple exactly when the end is aligned.
    // A start below an end that fits in memory fits as well.
    bad_nxt = (|begin_r[ppr_pkg::PAGE_BITS-1:0]) || (|limit_r[ppr_pkg::PAGE_BITS-1:0]) ||
              (begin_r >= limit_r) || (limit_r > mem_bytes_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      q_lo_r <= q_lo_nxt;
      q_hi_r <= q_hi_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // Range table.
  logic [ppr_pkg::CNT_W-1:0]   count_r;
  logic [ppr_pkg::CNT_W-1:0]   count_nxt;
  logic [ppr_pkg::IDX_W-1:0]   idx_r;
  logic [ppr_pkg::IDX_W-1:0]   idx_nxt;
  logic                        cmp_v_r;
  logic                        full;
  logic                        wr_en;
  ppr_pkg::entry_t             wr_entry;
  ppr_pkg::entry_t             rd_entry;
  logic [ppr_pkg::ENTRY_W-1:0] rd_data;
  ppr_pkg::status_t            status_r;
  ppr_pkg::status_t            status_nxt;

  assign full     = count_r >= ppr_pkg::CNT_W'(ppr_pkg::MAX_REGIONS);
  assign wr_entry = '{start_addr: begin_r, end_addr: limit_r, rights: rights_r};
  assign rd_entry = ppr_pkg::entry_t'(rd_data);

  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    if (cmd.prep) begin
      status_nxt = ppr_pkg::ST_OK;
    end else if (cmd.rec) begin
      if (bad_r) begin
        status_nxt = ppr_pkg::ST_BAD;
      end else if (rights_r[ppr_pkg::W_BIT] && rights_r[ppr_pkg::X_BIT]) begin
        status_nxt = ppr_pkg::ST_WX;
      end else if (full) begin
        status_nxt = ppr_pkg::ST_FULL;
      end else begin
        status_nxt = ppr_pkg::ST_OK;
        wr_en      = 1'b1;
        count_nxt  = count_r + ppr_pkg::CNT_W'(1);
      end
    end
    if (cmd.prep) begin
      idx_nxt = '0;
    end else if (cmd.scan_rd) begin
      idx_nxt = idx_r + ppr_pkg::IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cmp_v_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

  ppr_ram #(
    .WIDTH(ppr_pkg::ENTRY_W),
    .DEPTH(ppr_pkg::MAX_REGIONS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count_r[ppr_pkg::IDX_W-1:0]),
    .wdata(wr_entry),
    .raddr(idx_r),
    .rdata(rd_data)
  );

  // Compare stage on the registered read data.
  logic                         touch;
  logic                         hit_r;
  logic                         hit_nxt;
  logic [ppr_pkg::RIGHTS_W-1:0] acc_r;
  logic [ppr_pkg::RIGHTS_W-1:0] acc_nxt;

  always_comb begin
    touch   = ({1'b0, rd_entry.start_addr} < q_hi_r) && (q_lo_r < rd_entry.end_addr);
    hit_nxt = hit_r;
    acc_nxt = acc_r;
    if (cmd.prep) begin
      hit_nxt = 1'b0;
      acc_nxt = '0;
    end else if (cmp_v_r && touch) begin
      hit_nxt = 1'b1;
      // A lookup keeps the first matching range; a union ORs them all.
      if (kind_r == ppr_pkg::KIND_UNION) begin
        acc_nxt = acc_r | rd_entry.rights;
      end else if (!hit_r) begin
        acc_nxt = rd_entry.rights;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    acc_r <= acc_nxt;
  end

  // Result formatting and output register.
  ppr_pkg::status_t              res_status;
  logic                          res_covered;
  logic [ppr_pkg::RIGHTS_W-1:0]  res_rights;
  logic [ppr_pkg::ADDR_BITS-1:0] res_entry;
  logic                          res_hw;
  logic                          res_s2r;
  logic                          res_s2w;
  logic                          res_s2x;
  logic [ppr_pkg::ADDR_BITS-ppr_pkg::PAGE_BITS-1:0] pfn;

  assign pfn = q_lo_r[ppr_pkg::ADDR_BITS-1:ppr_pkg::PAGE_BITS];

  always_comb begin
    res_status  = ppr_pkg::ST_OK;
    res_covered = 1'b0;
    res_rights  = '0;
    res_entry   = '0;
    res_hw      = 1'b0;
    res_s2r     = 1'b0;
    res_s2w     = 1'b0;
    res_s2x     = 1'b0;
    case (kind_r)
      ppr_pkg::KIND_RECORD: res_status = status_r;
      ppr_pkg::KIND_LOOKUP: begin
        res_covered = hit_r;
        res_rights  = acc_r;
        if (!hit_r || acc_r[ppr_pkg::W_BIT]) begin
          res_entry = {pfn, flags_rw_r};
        end else if (acc_r[ppr_pkg::X_BIT]) begin
          res_entry = {pfn, flags_rx_r};
        end else if (acc_r[ppr_pkg::R_BIT]) begin
          res_entry = {pfn, flags_ro_r};
        end
      end
      ppr_pkg::KIND_UNION: begin
        if (hit_r) begin
          res_covered = 1'b1;
          res_rights  = acc_r;
          res_hw      = acc_r[ppr_pkg::W_BIT];
          res_s2r     = acc_r[ppr_pkg::R_BIT] | acc_r[ppr_pkg::X_BIT];
          res_s2w     = acc_r[ppr_pkg::W_BIT];
          res_s2x     = acc_r[ppr_pkg::X_BIT];
        end
      end
      default: ;
    endcase
  end

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  ppr_pkg::status_t              out_status_r;
  logic                          out_covered_r;
  logic [ppr_pkg::RIGHTS_W-1:0]  out_rights_r;
  logic [ppr_pkg::ADDR_BITS-1:0] out_entry_r;
  logic                          out_hw_r;
  logic                          out_s2r_r;
  logic                          out_s2w_r;
  logic                          out_s2x_r;

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= res_status;
      out_covered_r <= res_covered;
      out_rights_r  <= res_rights;
      out_entry_r   <= res_entry;
      out_hw_r      <= res_hw;
      out_s2r_r     <= res_s2r;
      out_s2w_r     <= res_s2w;
      out_s2x_r     <= res_s2x;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_covered      = out_covered_r;
  assign out_found_rights = out_rights_r;
  assign out_page_entry   = out_entry_r;
  assign out_host_write   = out_hw_r;
  assign out_stage2_read  = out_s2r_r;
  assign out_stage2_write = out_s2w_r;
  assign out_stage2_exec  = out_s2x_r;

  assign st.kind       = kind_r;
  assign st.count_zero = (count_r == '0);
  assign st.scan_last  = (ppr_pkg::CNT_W'(idx_r) == count_r - ppr_pkg::CNT_W'(1));
  assign st.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

>>> tb/page_protection_range_table_core_test.sv
`timescale 1ns / 1ps

module page_protection_range_table_core_test;

  localparam logic [ppr_pkg::RIGHTS_W-1:0] RD = 3'(1 << ppr_pkg::R_BIT);
  localparam logic [ppr_pkg::RIGHTS_W-1:0] WR = 3'(1 << ppr_pkg::W_BIT);
  localparam logic [ppr_pkg::RIGHTS_W-1:0] EX = 3'(1 << ppr_pkg::X_BIT);
  localparam logic [ppr_pkg::ADDR_BITS-1:0] ADDR_MAX = '1;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    ppr_pkg::kind_t                kind;
    logic [ppr_pkg::ADDR_BITS-1:0] range_lo;
    logic [ppr_pkg::ADDR_BITS-1:0] range_hi;
    logic [ppr_pkg::RIGHTS_W-1:0]  rights;
    logic [ppr_pkg::ADDR_BITS-1:0] page_address;
  } request_t;

  typedef struct packed {
    ppr_pkg::status_t              status;
    logic                          covered;
    logic [ppr_pkg::RIGHTS_W-1:0]  found_rights;
    logic [ppr_pkg::ADDR_BITS-1:0] page_entry;
    logic                          host_write;
    logic                          stage2_read;
    logic                          stage2_write;
    logic                          stage2_exec;
  } reply_t;

  // Mirror of the range table and its registers, plus the replies still owed.
  class range_table_tracker;
    logic [ppr_pkg::ADDR_BITS-1:0] mem_bytes;
    logic [ppr_pkg::SHIFT_W-1:0]   host_shift;
    logic [ppr_pkg::FLAG_W-1:0]    flags_rw;
    logic [ppr_pkg::FLAG_W-1:0]    flags_rx;
    logic [ppr_pkg::FLAG_W-1:0]    flags_ro;
    logic [ppr_pkg::ADDR_BITS-1:0] lo_tab[ppr_pkg::MAX_REGIONS];
    logic [ppr_pkg::ADDR_BITS-1:0] hi_tab[ppr_pkg::MAX_REGIONS];
    logic [ppr_pkg::RIGHTS_W-1:0]  rights_tab[ppr_pkg::MAX_REGIONS];
    int                            used;
    reply_t                        owed_replies[$];
    int                            errors;

    function new();
      mem_bytes  = '0;
      host_shift = ppr_pkg::SHIFT_W'(ppr_pkg::HPS_RESET);
      flags_rw   = '0;
      flags_rx   = '0;
      flags_ro   = '0;
      used       = 0;
      errors     = 0;
    endfunction

    function void write_reg(ppr_pkg::cfg_idx_t idx, logic [ppr_pkg::CFG_W-1:0] val);
      case (idx)
        ppr_pkg::CFG_MEM_SIZE: mem_bytes  = val[ppr_pkg::ADDR_BITS-1:0];
        ppr_pkg::CFG_HPS:      host_shift = val[ppr_pkg::SHIFT_W-1:0];
        ppr_pkg::CFG_FLAGS_RW: flags_rw   = val[ppr_pkg::FLAG_W-1:0];
        ppr_pkg::CFG_FLAGS_RX: flags_rx   = val[ppr_pkg::FLAG_W-1:0];
        ppr_pkg::CFG_FLAGS_RO: flags_ro   = val[ppr_pkg::FLAG_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // Works out the reply to one accepted request and updates the table.
    function void note_request(request_t rq);
      reply_t                        rp;
      logic [ppr_pkg::ADDR_BITS-1:0] span;
      logic [ppr_pkg::ADDR_BITS-1:0] pa;
      logic [ppr_pkg::RIGHTS_W-1:0]  acc;
      logic                          hit;
      int                            sh;
      logic [63:0]                   hsize;
      logic [63:0]                   hpa;
      rp = '0;
      case (rq.kind)
        ppr_pkg::KIND_RECORD: begin
          span = rq.range_hi - rq.range_lo;
          if (rq.range_lo[ppr_pkg::PAGE_BITS-1:0] != 0 || rq.range_lo >= rq.range_hi ||
              span[ppr_pkg::PAGE_BITS-1:0] != 0 || rq.range_lo > mem_bytes ||
              rq.range_hi > mem_bytes) begin
            rp.status = ppr_pkg::ST_BAD;
          end else if (rq.rights[ppr_pkg::W_BIT] && rq.rights[ppr_pkg::X_BIT]) begin
            rp.status = ppr_pkg::ST_WX;
          end else if (used >= ppr_pkg::MAX_REGIONS) begin
            rp.status = ppr_pkg::ST_FULL;
          end else begin
            lo_tab[used]     = rq.range_lo;
            hi_tab[used]     = rq.range_hi;
            rights_tab[used] = rq.rights;
            used++;
            rp.status = ppr_pkg::ST_OK;
          end
        end
        ppr_pkg::KIND_LOOKUP: begin
          pa  = (rq.page_address >> ppr_pkg::PAGE_BITS) << ppr_pkg::PAGE_BITS;
          hit = 1'b0;
          acc = '0;
          for (int i = 0; i < used; i++) begin
            if (!hit && lo_tab[i] <= pa && pa < hi_tab[i]) begin
              hit = 1'b1;
              acc = rights_tab[i];
            end
          end
          rp.covered      = hit;
          rp.found_rights = acc;
          if (!hit || acc[ppr_pkg::W_BIT])
            rp.page_entry = pa | ppr_pkg::ADDR_BITS'(flags_rw);
          else if (acc[ppr_pkg::X_BIT])
            rp.page_entry = pa | ppr_pkg::ADDR_BITS'(flags_rx);
          else if (acc[ppr_pkg::R_BIT])
            rp.page_entry = pa | ppr_pkg::ADDR_BITS'(flags_ro);
          else
            rp.page_entry = '0;
        end
        ppr_pkg::KIND_UNION: begin
          sh = int'(host_shift);
          if (sh < ppr_pkg::HPS_MIN) sh = ppr_pkg::HPS_MIN;
          if (sh > ppr_pkg::HPS_MAX) sh = ppr_pkg::HPS_MAX;
          hsize = 64'd1 << sh;
          hpa   = 64'(rq.page_address) & ~(hsize - 64'd1);
          hit   = 1'b0;
          acc   = '0;
          for (int i = 0; i < used; i++) begin
            if (!((64'(lo_tab[i]) > hpa && 64'(lo_tab[i]) - hpa >= hsize) ||
                  hpa >= 64'(hi_tab[i]))) begin
              hit = 1'b1;
              acc |= rights_tab[i];
            end
          end
          if (hit) begin
            rp.covered      = 1'b1;
            rp.found_rights = acc;
            rp.host_write   = acc[ppr_pkg::W_BIT];
            rp.stage2_read  = acc[ppr_pkg::R_BIT] | acc[ppr_pkg::X_BIT];
            rp.stage2_write = acc[ppr_pkg::W_BIT];
            rp.stage2_exec  = acc[ppr_pkg::X_BIT];
          end
        end
        default: ;
      endcase
      owed_replies.push_back(rp);
    endfunction

    function void compare(string name, logic [ppr_pkg::ADDR_BITS-1:0] want,
                          logic [ppr_pkg::ADDR_BITS-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = owed_replies.pop_front();
        compare("status", ppr_pkg::ADDR_BITS'(want.status), ppr_pkg::ADDR_BITS'(got.status));
        compare("covered", ppr_pkg::ADDR_BITS'(want.covered),
                ppr_pkg::ADDR_BITS'(got.covered));
        compare("found_rights", ppr_pkg::ADDR_BITS'(want.found_rights),
                ppr_pkg::ADDR_BITS'(got.found_rights));
        compare("page_entry", want.page_entry, got.page_entry);
        compare("host_write", ppr_pkg::ADDR_BITS'(want.host_write),
                ppr_pkg::ADDR_BITS'(got.host_write));
        compare("stage2_read", ppr_pkg::ADDR_BITS'(want.stage2_read),
                ppr_pkg::ADDR_BITS'(got.stage2_read));
        compare("stage2_write", ppr_pkg::ADDR_BITS'(want.stage2_write),
                ppr_pkg::ADDR_BITS'(got.stage2_write));
        compare("stage2_exec", ppr_pkg::ADDR_BITS'(want.stage2_exec),
                ppr_pkg::ADDR_BITS'(got.stage2_exec));
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [ppr_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [ppr_pkg::CFG_W-1:0]        cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       in_kind;
  logic [ppr_pkg::ADDR_BITS-1:0]    in_range_begin;
  logic [ppr_pkg::ADDR_BITS-1:0]    in_range_limit;
  logic [ppr_pkg::RIGHTS_W-1:0]     in_access_rights;
  logic [ppr_pkg::ADDR_BITS-1:0]    in_page_address;
  logic                             out_valid;
  logic                             out_stall;
  logic [1:0]                       out_status;
  logic                             out_covered;
  logic [ppr_pkg::RIGHTS_W-1:0]     out_found_rights;
  logic [ppr_pkg::ADDR_BITS-1:0]    out_page_entry;
  logic                             out_host_write;
  logic                             out_stage2_read;
  logic                             out_stage2_write;
  logic                             out_stage2_exec;

  range_table_tracker tracker;
  int send_idle_pct;
  int recv_stall_pct;

  page_protection_range_table_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_range_begin   (in_range_begin),
    .in_range_limit   (in_range_limit),
    .in_access_rights (in_access_rights),
    .in_page_address  (in_page_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_covered      (out_covered),
    .out_found_rights (out_found_rights),
    .out_page_entry   (out_page_entry),
    .out_host_write   (out_host_write),
    .out_stage2_read  (out_stage2_read),
    .out_stage2_write (out_stage2_write),
    .out_stage2_exec  (out_stage2_exec)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stall chosen at each falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_reply({ppr_pkg::status_t'(out_status), out_covered, out_found_rights,
                           out_page_entry, out_host_write, out_stage2_read,
                           out_stage2_write, out_stage2_exec});
  end

  function automatic logic [ppr_pkg::ADDR_BITS-1:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[ppr_pkg::ADDR_BITS-1:0];
  endfunction

  function automatic request_t mk(ppr_pkg::kind_t k, logic [ppr_pkg::ADDR_BITS-1:0] lo,
                                  logic [ppr_pkg::ADDR_BITS-1:0] hi,
                                  logic [ppr_pkg::RIGHTS_W-1:0] r,
                                  logic [ppr_pkg::ADDR_BITS-1:0] addr);
    request_t rq;
    rq.kind         = k;
    rq.range_lo     = lo;
    rq.range_hi     = hi;
    rq.rights       = r;
    rq.page_address = addr;
    return rq;
  endfunction

  // Entered and left at a falling edge; valid stays high if the next call follows directly.
  task automatic send_request(request_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= rq.kind;
    in_range_begin   <= rq.range_lo;
    in_range_limit   <= rq.range_hi;
    in_access_rights <= rq.rights;
    in_page_address  <= rq.page_address;
    do @(posedge clk); while (in_stall);
    tracker.note_request(rq);
    @(negedge clk);
  endtask

  // Stop sending, let every owed reply drain and give the block time to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(logic [ppr_pkg::CFG_W-1:0] mem,
                                logic [ppr_pkg::CFG_W-1:0] shift,
                                logic [ppr_pkg::CFG_W-1:0] rw,
                                logic [ppr_pkg::CFG_W-1:0] rx,
                                logic [ppr_pkg::CFG_W-1:0] ro);
    ppr_pkg::cfg_idx_t         idx[5];
    logic [ppr_pkg::CFG_W-1:0] val[5];
    idx = '{ppr_pkg::CFG_MEM_SIZE, ppr_pkg::CFG_HPS, ppr_pkg::CFG_FLAGS_RW,
            ppr_pkg::CFG_FLAGS_RX, ppr_pkg::CFG_FLAGS_RO};
    val = '{mem, shift, rw, rx, ro};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      tracker.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [ppr_pkg::CFG_W-1:0] rand_cfg(int hi);
    return ppr_pkg::CFG_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [ppr_pkg::ADDR_BITS-1:0] probe_address();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return rand48();
    else if (pick == 1)
      return 48'hFFFF_FFFF_E000 | ppr_pkg::ADDR_BITS'($urandom_range(0, 8191));
    else
      return (ppr_pkg::ADDR_BITS'($urandom_range(0, 300)) << ppr_pkg::PAGE_BITS) |
             ppr_pkg::ADDR_BITS'($urandom_range(0, 4095));
  endfunction

  // Mostly queries against a small address window; records are rare so the
  // table fills gradually over the run.
  task automatic send_random_items(int count);
    request_t rq;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      rq = mk(ppr_pkg::KIND_NONE, rand48(), rand48(), 3'($urandom_range(0, 7)),
              probe_address());
      if (pick < 6) begin
        rq.kind = ppr_pkg::KIND_RECORD;
        if ($urandom_range(0, 4) != 0) begin
          rq.range_lo = ppr_pkg::ADDR_BITS'($urandom_range(0, 255)) << ppr_pkg::PAGE_BITS;
          rq.range_hi = rq.range_lo +
                        (ppr_pkg::ADDR_BITS'($urandom_range(1, 8)) << ppr_pkg::PAGE_BITS);
        end
      end else if (pick < 50) begin
        rq.kind = ppr_pkg::KIND_LOOKUP;
      end else if (pick < 92) begin
        rq.kind = ppr_pkg::KIND_UNION;
      end
      send_request(rq);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = ppr_pkg::CFG_MEM_SIZE;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_kind          = ppr_pkg::KIND_RECORD;
    in_range_begin   = '0;
    in_range_limit   = '0;
    in_access_rights = '0;
    in_page_address  = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    tracker = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: memory size zero rejects every range.
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h0, 48'h1000, RD, 48'h0));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, ADDR_MAX));
    send_request(mk(ppr_pkg::KIND_UNION, 48'h0, 48'h0, 3'b000, 48'h0));
    send_request(mk(ppr_pkg::KIND_NONE, ADDR_MAX, ADDR_MAX, 3'b111, ADDR_MAX));
    settle();

    // Bound checks against a small memory.
    write_settings(48'h10000, 48'd12, 48'h003, 48'h801, 48'hFFF);
    send_request(mk(ppr_pkg::KIND_RECORD, 48'hF000, 48'h11000, RD, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h10000, 48'h11000, RD, 48'h0));
    settle();

    write_settings(ADDR_MAX, 48'd12, 48'h003, 48'h801, 48'hFFF);
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h1001, 48'h3000, RD, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h3000, 48'h3000, RD, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h3000, 48'h2000, RD, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h3000, 48'h3800, RD, 48'h0));
    // A bad range wins over write+execute.
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h1000, 48'h1234, WR | EX, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h1000, 48'h3000, WR | EX, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h1000, 48'h3000, RD, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h3000, 48'h4000, WR, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h4000, 48'h6000, RD | EX, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h6000, 48'h7000, 3'b000, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'h7000, 48'h9000, RD | WR, 48'h0));
    send_request(mk(ppr_pkg::KIND_RECORD, 48'hFFFF_FFFF_E000, 48'hFFFF_FFFF_F000, EX,
                    48'h0));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, 48'h1ABC));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, 48'h3FFF));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, 48'h4000));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, 48'h6123));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, 48'hFFFF_FFFF_E777));
    send_request(mk(ppr_pkg::KIND_LOOKUP, 48'h0, 48'h0, 3'b000, 48'h9000));
    // Write-only range: the union must not grant stage-2 read.
    send_request(mk(ppr_pkg::KIND_UNION, 48'h0, 48'h0, 3'b000, 48'h3000));
    send_request(mk(ppr_pkg::KIND_UNION, 48'h0, 48'h0, 3'b000, 48'h5FFF));
    settle();

    write_settings(ADDR_MAX, 48'd16, 48'hFFF, 48'h000, 48'h555);
    send_request(mk(ppr_pkg::KIND_UNION, 48'h0, 48'h0, 3'b000, 48'hFFFF));
    send_request(mk(ppr_pkg::KIND_UNION, 48'h0, 48'h0, 3'b000, ADDR_MAX));
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_settings(ADDR_MAX, 48'd14, rand_cfg(4095), rand_cfg(4095), rand_cfg(4095));
        1: write_settings(48'h80000, 48'd0, 48'd0, 48'd0, 48'd0);
        2: write_settings(ADDR_MAX, 48'd31, 48'hFFF, 48'hFFF, 48'hFFF);
        3: write_settings(48'h0, 48'd16, rand_cfg(4095), rand_cfg(4095), rand_cfg(4095));
        4: write_settings(rand48(), rand_cfg(31), rand48(), rand48(), rand48());
        default: write_settings(ADDR_MAX, 48'd13, rand_cfg(4095), rand_cfg(4095),
                                rand_cfg(4095));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      send_random_items(90);
      settle();
    end

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
